// ----- rtl/core/adaa_wf_pkg.sv -----
// ----------------------------------------------------------------------------
// adaa_wf_pkg
// Shared types and constants of the two-stage antialiased wavefolder.
// ----------------------------------------------------------------------------
package adaa_wf_pkg;

   localparam int    FRACTION_BITS        = 21;
   localparam int    DEFAULT_NUM_CHANNELS = 16;

   localparam int    SAMPLE_W = 24;
   localparam int    THRESH_W = 22;
   localparam int    CHAN_W   = 4;
   localparam int    DIFF_W   = SAMPLE_W + 1;
   localparam int    MUL_W    = 28;
   localparam int    ACC_W    = 2 * MUL_W;
   localparam int    QUOT_W   = 24;
   localparam int    ENTRY_W  = 2 * SAMPLE_W;

   localparam longint ONE          = longint'(1) << FRACTION_BITS;
   localparam longint CQ           = (ONE + 5) / 10;
   localparam longint TQ           = 2 * ONE + CQ;
   localparam longint NEAR_LIMIT   = (ONE - 1) / 100000;
   localparam longint FOLD_CONST   = 2 * ONE * ONE;
   localparam longint CLIP_CONST   = 2 * ONE * ONE - CQ * CQ;
   localparam longint SMAX         = 8388607;
   localparam longint SMIN         = -8388608;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [ACC_W-1:0]    acc_type;
   typedef logic signed [DIFF_W-1:0]   diff_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHAN,
      S_READ,
      S_DIFF,
      S_PICK,
      S_MUL,
      S_ACC,
      S_DIVGO,
      S_DIVWAIT,
      S_NEXT,
      S_FINISH
   } wf_state_type;

endpackage

// ----- rtl/core/adaa_wf_state_mem.sv -----
// ----------------------------------------------------------------------------
// adaa_wf_state_mem
// Per-channel store of the last stage inputs, one read port with a
// registered output and one write port; entries not yet written read as zero.
// ----------------------------------------------------------------------------
module adaa_wf_state_mem
   import adaa_wf_pkg::*;
#(
   parameter int DEPTH = DEFAULT_NUM_CHANNELS,
   parameter int AW    = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output logic [ENTRY_W-1:0] rd_data,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [ENTRY_W-1:0] wr_data
);

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]   valid_ff;
   logic [ENTRY_W-1:0] rd_raw_ff;
   logic               rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_raw_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_raw_ff : '0;

endmodule

// ----- rtl/core/adaa_wf_divider.sv -----
// ----------------------------------------------------------------------------
// adaa_wf_divider
// Restoring divider, one quotient bit per cycle: round(num / (2 * den)),
// saturated to the sample range.
// ----------------------------------------------------------------------------
module adaa_wf_divider
   import adaa_wf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  acc_type    num,
   input  diff_type   den,
   output logic       done,
   output sample_type quot
);

   localparam int REM_W = ACC_W + 1;
   localparam int CNT_W = $clog2(QUOT_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [REM_W-1:0]  dsh_ff, dsh_in;
   logic [QUOT_W-1:0] q_ff, q_in;
   logic              neg_ff, neg_in;
   logic              ovf_ff, ovf_in;

   logic [ACC_W-1:0]  un;
   logic [DIFF_W-1:0] ud;
   logic [REM_W-1:0]  dividend;
   logic [REM_W-1:0]  divisor;

   always_comb begin
      un       = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
      ud       = den[DIFF_W-1] ? DIFF_W'(-den) : DIFF_W'(den);
      dividend = REM_W'(un) + REM_W'(ud);
      divisor  = REM_W'(ud) << 1;

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      ovf_in  = ovf_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QUOT_W);
         rem_in  = dividend;
         dsh_in  = divisor << (QUOT_W - 1);
         q_in    = '0;
         neg_in  = num[ACC_W-1] ^ den[DIFF_W-1];
         ovf_in  = dividend >= (divisor << QUOT_W);
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            q_in   = {q_ff[QUOT_W-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[QUOT_W-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
      ovf_ff <= ovf_in;
   end

   always_comb begin
      if (neg_ff) begin
         if (ovf_ff || (q_ff > QUOT_W'(-SMIN))) begin
            quot = SAMPLE_W'(SMIN);
         end else begin
            quot = SAMPLE_W'(-$signed({1'b0, q_ff}));
         end
      end else begin
         if (ovf_ff || (q_ff > QUOT_W'(SMAX))) begin
            quot = SAMPLE_W'(SMAX);
         end else begin
            quot = $signed(q_ff);
         end
      end
   end

   assign done = done_ff;

endmodule

// ----- rtl/core/adaa_two_stage_wavefolder_top.sv -----
// ----------------------------------------------------------------------------
// adaa_two_stage_wavefolder_top
// Two wavefolder stages in series, each antialiased with first-order
// antiderivatives; last inputs of both stages kept per channel in memory.
// ----------------------------------------------------------------------------
//  channel  direction  ports                                          transfer
//  req      in         req_sample_in, req_fold_threshold, req_channel valid & !stall
//  rsp      out        rsp_sample_out                                 valid & !stall
//
//  Each stage either takes the midpoint or runs the 24-step divider;
//  channel reduction subtracts NUM_CHANNELS from the channel until it
//  lies in the store's range.
//  Reset clears the control state and marks every channel's entry as zero.
//  The result register lets a new request in while rsp is stalled.
// ----------------------------------------------------------------------------
module adaa_two_stage_wavefolder_top
   import adaa_wf_pkg::*;
#(
   parameter int NUM_CHANNELS = DEFAULT_NUM_CHANNELS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [SAMPLE_W-1:0] req_sample_in,
   input  logic [THRESH_W-1:0] req_fold_threshold,
   input  logic [CHAN_W-1:0]   req_channel,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SAMPLE_W-1:0] rsp_sample_out
);

   localparam int        CH_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [6:0] CH_LIMIT = 7'(NUM_CHANNELS);
   localparam logic [CHAN_W-1:0] CH_SUB = CHAN_W'(NUM_CHANNELS);

   typedef logic signed [MUL_W-1:0] mul_type;

   wf_state_type state_ff, state_in;

   sample_type          x_ff, x_in;
   logic [THRESH_W-1:0] t_ff, t_in;
   logic [CHAN_W-1:0]   ch_ff, ch_in;
   sample_type          p2_ff, p2_in;
   sample_type          y1_ff, y1_in;
   sample_type          a_ff, a_in;
   sample_type          b_ff, b_in;
   logic                stage_ff, stage_in;
   diff_type            d_ff, d_in;
   sample_type          mid_ff, mid_in;
   logic                near_ff, near_in;
   acc_type             acc_ff, acc_in;
   acc_type             prod_ff, prod_in;
   logic                prod_neg_ff, prod_neg_in;
   logic                prod_vld_ff, prod_vld_in;
   logic [2:0]          mk_ff, mk_in;
   sample_type          y_ff, y_in;
   logic                rsp_valid_ff, rsp_valid_in;
   sample_type          rsp_data_ff, rsp_data_in;

   logic               mem_rd, mem_wr;
   logic [CH_W-1:0]    mem_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic               div_start, div_done;
   sample_type         div_quot;

   diff_type   sum;
   diff_type   dabs;
   sample_type v;
   logic [1:0] slot;
   mul_type    vw, tw, uw, ten_t, op_a, op_b, fold_w;
   acc_type    cterm, padd;
   logic       v_gt, v_lt;
   sample_type f1_mid, f2_mid;

   function automatic sample_type sat_mul(input mul_type val);
      if (val > MUL_W'(SMAX)) begin
         return SAMPLE_W'(SMAX);
      end else if (val < MUL_W'(SMIN)) begin
         return SAMPLE_W'(SMIN);
      end
      return SAMPLE_W'(val);
   endfunction

   function automatic sample_type one_mid(input sample_type m, input mul_type t);
      mul_type mw;
      mw = MUL_W'(m);
      if (mw > t) begin
         return sat_mul((t <<< 2) + t - (mw <<< 2));
      end else if (mw < -t) begin
         return sat_mul(-((t <<< 2) + t) - (mw <<< 2));
      end
      return m;
   endfunction

   function automatic sample_type two_mid(input sample_type m);
      mul_type mw;
      mw = MUL_W'(m);
      if (mw < -MUL_W'(TQ)) begin
         return SAMPLE_W'(CQ);
      end else if (mw < -MUL_W'(ONE)) begin
         return sat_mul(-(mw + MUL_W'(2 * ONE)));
      end else if (mw < MUL_W'(ONE)) begin
         return m;
      end else if (mw < MUL_W'(TQ)) begin
         return sat_mul(MUL_W'(2 * ONE) - mw);
      end
      return SAMPLE_W'(-CQ);
   endfunction

   assign mem_addr = CH_W'(ch_ff);

   adaa_wf_state_mem #(
      .DEPTH (NUM_CHANNELS),
      .AW    (CH_W)
   ) u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd),
      .rd_addr (mem_addr),
      .rd_data (rd_data),
      .wr_en   (mem_wr),
      .wr_addr (mem_addr),
      .wr_data ({y1_ff, x_ff})
   );

   adaa_wf_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (acc_ff),
      .den   (d_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // operand selection for the shared multiplier
   always_comb begin
      sum    = DIFF_W'(a_ff) + DIFF_W'(b_ff);
      dabs   = d_ff[DIFF_W-1] ? -d_ff : d_ff;
      v      = (mk_ff < 3'd3) ? a_ff : b_ff;
      slot   = (mk_ff < 3'd3) ? mk_ff[1:0] : 2'(mk_ff - 3'd3);
      vw     = MUL_W'(v);
      tw     = MUL_W'(t_ff);
      uw     = (vw < 0) ? -vw : vw;
      ten_t  = (tw <<< 3) + (tw <<< 1);
      fold_w = uw - MUL_W'(2 * ONE);
      v_gt   = vw > tw;
      v_lt   = vw < -tw;
      op_a   = '0;
      op_b   = '0;
      cterm  = '0;
      if (!stage_ff) begin
         case (slot)
            2'd0: begin
               op_a = (v_gt || v_lt) ? -(vw <<< 2) : vw;
               op_b = vw;
            end
            2'd1: begin
               if (v_gt) begin
                  op_a = ten_t;
                  op_b = vw;
               end else if (v_lt) begin
                  op_a = -ten_t;
                  op_b = vw;
               end
            end
            2'd2: begin
               if (v_gt || v_lt) begin
                  op_a = -((tw <<< 2) + tw);
                  op_b = tw;
               end
            end
            default: begin
               op_a = '0;
               op_b = '0;
            end
         endcase
      end else if (slot == 2'd0) begin
         if (uw < MUL_W'(ONE)) begin
            op_a = uw;
            op_b = uw;
         end else if (uw < MUL_W'(TQ)) begin
            op_a  = -fold_w;
            op_b  = fold_w;
            cterm = ACC_W'(FOLD_CONST);
         end else begin
            op_a  = -MUL_W'(2 * CQ);
            op_b  = uw - MUL_W'(TQ);
            cterm = ACC_W'(CLIP_CONST);
         end
      end
      if (mk_ff >= 3'd3) begin
         cterm = -cterm;
      end
      padd   = prod_vld_ff ? (prod_neg_ff ? -prod_ff : prod_ff) : '0;
      f1_mid = one_mid(mid_ff, tw);
      f2_mid = two_mid(mid_ff);
   end

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      t_in         = t_ff;
      ch_in        = ch_ff;
      p2_in        = p2_ff;
      y1_in        = y1_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      stage_in     = stage_ff;
      d_in         = d_ff;
      mid_in       = mid_ff;
      near_in      = near_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      prod_neg_in  = prod_neg_ff;
      prod_vld_in  = prod_vld_ff;
      mk_in        = mk_ff;
      y_in         = y_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_rd       = 1'b0;
      mem_wr       = 1'b0;
      div_start    = 1'b0;
      req_stall    = (state_ff != S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_in     = req_sample_in;
               t_in     = req_fold_threshold;
               ch_in    = req_channel;
               state_in = S_CHAN;
            end
         end
         S_CHAN: begin
            // reduce the channel number into the store's range
            if ({3'b000, ch_ff} >= CH_LIMIT) begin
               ch_in = ch_ff - CH_SUB;
            end else begin
               mem_rd   = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            a_in     = x_ff;
            b_in     = rd_data[SAMPLE_W-1:0];
            p2_in    = rd_data[ENTRY_W-1:SAMPLE_W];
            stage_in = 1'b0;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            d_in     = DIFF_W'(a_ff) - DIFF_W'(b_ff);
            mid_in   = sum[DIFF_W-1:1];
            state_in = S_PICK;
         end
         S_PICK: begin
            near_in = dabs <= DIFF_W'(NEAR_LIMIT);
            if (dabs <= DIFF_W'(NEAR_LIMIT)) begin
               y_in     = stage_ff ? f2_mid : f1_mid;
               state_in = S_NEXT;
            end else begin
               acc_in      = '0;
               prod_vld_in = 1'b0;
               mk_in       = '0;
               state_in    = S_MUL;
            end
         end
         S_MUL: begin
            prod_in     = op_a * op_b;
            prod_neg_in = mk_ff >= 3'd3;
            prod_vld_in = 1'b1;
            acc_in      = acc_ff + padd + cterm;
            mk_in       = mk_ff + 3'd1;
            if (mk_ff == 3'd5) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            acc_in      = acc_ff + padd;
            prod_vld_in = 1'b0;
            state_in    = S_DIVGO;
         end
         S_DIVGO: begin
            div_start = 1'b1;
            state_in  = S_DIVWAIT;
         end
         S_DIVWAIT: begin
            if (div_done) begin
               y_in     = div_quot;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (!stage_ff) begin
               y1_in    = y_ff;
               a_in     = y_ff;
               b_in     = p2_ff;
               stage_in = 1'b1;
               state_in = S_DIFF;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               mem_wr       = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = y_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      t_ff        <= t_in;
      ch_ff       <= ch_in;
      p2_ff       <= p2_in;
      y1_ff       <= y1_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      stage_ff    <= stage_in;
      d_ff        <= d_in;
      mid_ff      <= mid_in;
      near_ff     <= near_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      prod_neg_ff <= prod_neg_in;
      prod_vld_ff <= prod_vld_in;
      mk_ff       <= mk_in;
      y_ff        <= y_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_CHAN))
      else $error("accepted request did not start channel reduction");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIVWAIT))
      else $error("divider finished outside its wait state");

   a_write_free: assert property (@(posedge clock) disable iff (reset)
      mem_wr |=> (rsp_valid_ff && (state_ff == S_IDLE)))
      else $error("state write without result load");

   a_midpoint_skips_div: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_NEXT) && near_ff) |-> !div_done)
      else $error("divider active on midpoint path");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-stage antialiased wavefolder: drives
// samples in bursts with a stalling receiver, predicts each folded sample
// with a per-channel model of both stages and compares in order.
// ----------------------------------------------------------------------------
module tb;
   import adaa_wf_pkg::*;

   localparam int NCH       = DEFAULT_NUM_CHANNELS;
   localparam int N_RANDOM  = 1630;
   localparam int IDLE_MAX  = 20000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample_in = '0;
   logic [THRESH_W-1:0] req_fold_threshold = '0;
   logic [CHAN_W-1:0]   req_channel = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [SAMPLE_W-1:0] rsp_sample_out;

   adaa_two_stage_wavefolder_top uut (.*);

   always #4 clock = ~clock;

   typedef struct {
      logic [SAMPLE_W-1:0] smp;
      logic [THRESH_W-1:0] thr;
      logic [CHAN_W-1:0]   ch;
      bit                  fixed;
      logic [SAMPLE_W-1:0] want;
   } stim_row_type;

   longint fold1_last[NCH];
   longint fold2_last[NCH];
   logic [SAMPLE_W-1:0] folded_queue[$];
   int  errors = 0;
   int  idle_cycles = 0;
   bit  send_done = 1'b0;
   bit  hold_off = 1'b0;

   function automatic longint clamp24(longint v);
      return v > SMAX ? SMAX : (v < SMIN ? SMIN : v);
   endfunction

   function automatic longint half_floor(longint a, longint b);
      return (a + b) >>> 1;
   endfunction

   function automatic bit is_close(longint d);
      longint u;
      u = d < 0 ? -d : d;
      return u * 100000 < ONE;
   endfunction

   function automatic longint round_quot(longint num, longint d);
      longint un, ud, q;
      un = num < 0 ? -num : num;
      ud = d < 0 ? -d : d;
      q = (un + ud) / (2 * ud);
      if ((num < 0) != (d < 0)) return q > 8388608 ? SMIN : -q;
      return q > SMAX ? SMAX : q;
   endfunction

   function automatic longint curve1(longint x, longint t);
      if (x > t) return 5 * t - 4 * x;
      if (x < -t) return -5 * t - 4 * x;
      return x;
   endfunction

   function automatic longint area1(longint x, longint t);
      if (x > t) return 10 * t * x - 4 * x * x - 5 * t * t;
      if (x < -t) return -10 * t * x - 4 * x * x - 5 * t * t;
      return x * x;
   endfunction

   function automatic longint curve2(longint x);
      if (x < -TQ) return CQ;
      if (x < -ONE) return -(x + 2 * ONE);
      if (x < ONE) return x;
      if (x < TQ) return 2 * ONE - x;
      return -CQ;
   endfunction

   function automatic longint area2(longint x);
      longint u;
      u = x < 0 ? -x : x;
      if (u < ONE) return u * u;
      if (u < TQ) return 2 * ONE * ONE - (u - 2 * ONE) * (u - 2 * ONE);
      return 2 * ONE * ONE - CQ * CQ - 2 * CQ * (u - TQ);
   endfunction

   // Advance both stages of one channel and return the folded sample.
   function automatic logic [SAMPLE_W-1:0] fold_sample(logic [SAMPLE_W-1:0] smp,
         logic [THRESH_W-1:0] thr, logic [CHAN_W-1:0] chan);
      int     c;
      longint x, t, p, y1, y2;
      c = chan % NCH;
      x = longint'(sample_type'(smp));
      t = longint'(thr);
      p = fold1_last[c];
      if (is_close(x - p)) y1 = clamp24(curve1(half_floor(x, p), t));
      else y1 = round_quot(area1(x, t) - area1(p, t), x - p);
      fold1_last[c] = x;
      p = fold2_last[c];
      if (is_close(y1 - p)) y2 = clamp24(curve2(half_floor(y1, p)));
      else y2 = round_quot(area2(y1) - area2(p), y1 - p);
      fold2_last[c] = y1;
      return y2[SAMPLE_W-1:0];
   endfunction

   task automatic send_sample(logic [SAMPLE_W-1:0] smp, logic [THRESH_W-1:0] thr,
         logic [CHAN_W-1:0] chan, bit fixed, logic [SAMPLE_W-1:0] want);
      logic [SAMPLE_W-1:0] model;
      req_valid <= 1'b1;
      req_sample_in <= smp;
      req_fold_threshold <= thr;
      req_channel <= chan;
      do @(posedge clock); while (req_stall);
      model = fold_sample(smp, thr, chan);
      if (fixed && model !== want)
         $display("%0t directed row disagrees with model: want %h model %h",
                  $time, want, model);
      folded_queue.push_back(fixed ? want : model);
      @(negedge clock);
   endtask

   task automatic pause_sender();
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clock);
   endtask

   // Random sample biased toward fold edges, the clip knee and small steps.
   function automatic logic [SAMPLE_W-1:0] pick_sample(int c);
      case ($urandom_range(0, 5))
         0: return SAMPLE_W'(fold1_last[c] + $urandom_range(0, 40) - 20);
         1: return SAMPLE_W'($urandom_range(0, 1) ? TQ + $urandom_range(0, 8) - 4
                                                  : -TQ + $urandom_range(0, 8) - 4);
         2: return SAMPLE_W'($urandom_range(0, 1) ? ONE - 2 + $urandom_range(0, 4)
                                                  : -ONE - 2 + $urandom_range(0, 4));
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   stim_row_type directed[] = '{
      '{24'h000000, 22'h200000, 4'd0, 1'b1, 24'h000000},
      '{24'h7FFFFF, 22'h3FFFFF, 4'd1, 1'b0, 24'h0},
      '{24'h800000, 22'h3FFFFF, 4'd1, 1'b0, 24'h0},
      '{24'h800000, 22'h000000, 4'd2, 1'b0, 24'h0},
      '{24'h7FFFFF, 22'h000000, 4'd2, 1'b0, 24'h0},
      '{24'h7FFFFF, 22'h000000, 4'd2, 1'b0, 24'h0},
      '{24'h100000, 22'h200000, 4'd3, 1'b0, 24'h0},
      '{24'h100005, 22'h200000, 4'd3, 1'b0, 24'h0},
      '{24'h300000, 22'h080000, 4'd4, 1'b0, 24'h0},
      '{24'hD00000, 22'h080000, 4'd4, 1'b0, 24'h0},
      '{24'h200000, 22'h200000, 4'd5, 1'b0, 24'h0},
      '{24'h433333, 22'h3FFFFF, 4'd6, 1'b0, 24'h0},
      '{24'hBCCCCD, 22'h3FFFFF, 4'd6, 1'b0, 24'h0},
      '{24'h400000, 22'h3FFFFF, 4'd7, 1'b0, 24'h0},
      '{24'h000015, 22'h155555, 4'd8, 1'b0, 24'h0},
      '{24'hFFFFEB, 22'h155555, 4'd8, 1'b0, 24'h0},
      '{24'h5A5A5A, 22'h2AAAAA, 4'd15, 1'b0, 24'h0},
      '{24'hA5A5A5, 22'h155555, 4'd9, 1'b0, 24'h0},
      '{24'h123456, 22'h100000, 4'd10, 1'b0, 24'h0}
   };

   initial begin
      int c;
      logic [THRESH_W-1:0] thr;
      for (int i = 0; i < NCH; i++) begin
         fold1_last[i] = 0;
         fold2_last[i] = 0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i])
         send_sample(directed[i].smp, directed[i].thr, directed[i].ch,
                     directed[i].fixed, directed[i].want);
      pause_sender();
      for (int n = 0; n < N_RANDOM; n++) begin
         c = $urandom_range(0, NCH - 1);
         case ($urandom_range(0, 3))
            0: thr = THRESH_W'($urandom);
            1: thr = THRESH_W'($urandom_range(0, 2097152));
            2: thr = $urandom_range(0, 1) ? 22'h0 : 22'h200000;
            default: thr = $urandom_range(0, 1) ? 22'h3FFFFF : 22'h080000;
         endcase
         send_sample(pick_sample(c), thr, CHAN_W'(c), 1'b0, '0);
         if ($urandom_range(0, 9) == 0) pause_sender();
      end
      req_valid <= 1'b0;
      send_done = 1'b1;
   end

   // Receiver: random stall pattern, with one long hold-off early on.
   initial begin
      int hold_count;
      @(negedge clock);
      while (!send_done) begin
         @(negedge clock);
         if (!hold_off && folded_queue.size() != 0 && $time > 40000) begin
            hold_off = 1'b1;
            rsp_stall <= 1'b1;
            for (hold_count = 0; hold_count < 400; hold_count++) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (($time / 800) % 4 == 0) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
         end
      end
      rsp_stall <= 1'b0;
   end

   always @(posedge clock) begin
      logic [SAMPLE_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (folded_queue.size() == 0) begin
            $display("%0t unexpected transfer: actual %h", $time, rsp_sample_out);
            errors++;
         end else begin
            want = folded_queue.pop_front();
            if (rsp_sample_out !== want) begin
               $display("%0t sample_out mismatch: expected %h actual %h",
                        $time, want, rsp_sample_out);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_MAX) begin
         $display("adaa_two_stage_wavefolder_top test failed");
         $finish;
      end
   end

   initial begin
      wait (send_done);
      while (folded_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0 && folded_queue.size() == 0) begin
         $display("adaa_two_stage_wavefolder_top test passed");
      end else begin
         $display("adaa_two_stage_wavefolder_top test failed");
      end
      $finish;
   end

endmodule
